// ===== rtl/core/scse_pkg.sv =====
// Shared types and constants for the square tone channel.
// Used by the controller, the datapath and the top level.
`default_nettype none
package scse_pkg;

    localparam logic [2:0] KIND_WRITE  = 3'd0;
    localparam logic [2:0] KIND_READ   = 3'd1;
    localparam logic [2:0] KIND_LENGTH = 3'd2;
    localparam logic [2:0] KIND_ENV    = 3'd3;
    localparam logic [2:0] KIND_SWEEP  = 3'd4;
    localparam logic [2:0] KIND_SAMPLE = 3'd5;

    localparam logic [2:0] REG_SWEEP = 3'd0;
    localparam logic [2:0] REG_LEN   = 3'd1;
    localparam logic [2:0] REG_ENV   = 3'd2;
    localparam logic [2:0] REG_FLO   = 3'd3;
    localparam logic [2:0] REG_FHI   = 3'd4;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic load;
        logic apply;
        logic mul_init;
        logic mul_step;
        logic div_init;
        logic div_step;
        logic finish;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic mul_done;
        logic div_done;
    } t_stat;

    function automatic logic [15:0] vol_mag(input logic [3:0] v);
        logic [15:0] m;
        unique case (v)
            4'd0:  m = 16'd0;
            4'd1:  m = 16'd2184;
            4'd2:  m = 16'd4368;
            4'd3:  m = 16'd6553;
            4'd4:  m = 16'd8737;
            4'd5:  m = 16'd10922;
            4'd6:  m = 16'd13106;
            4'd7:  m = 16'd15291;
            4'd8:  m = 16'd17475;
            4'd9:  m = 16'd19660;
            4'd10: m = 16'd21844;
            4'd11: m = 16'd24029;
            4'd12: m = 16'd26213;
            4'd13: m = 16'd28398;
            4'd14: m = 16'd30582;
            default: m = 16'd32767;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] duty_pattern(input logic [1:0] d);
        logic [7:0] p;
        unique case (d)
            2'd0: p = 8'h80;
            2'd1: p = 8'h81;
            2'd2: p = 8'hE1;
            default: p = 8'h7E;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/scse_ctrl.sv =====
// Sequencer for the square tone channel: issues datapath commands.
// Depends on scse_pkg.
`default_nettype none
module scse_ctrl import scse_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd      o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_MUL, S_DINIT, S_DIV, S_FIN, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   emit;

    assign emit        = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        n_state        = r_state;
        o_cmd.emit     = emit;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.apply    = 1'b1;
                o_cmd.mul_init = i_stat.need_div;
                n_state        = i_stat.need_div ? S_MUL : S_DONE;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.mul_done) n_state = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (emit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/scse_dp.sv =====
// Datapath: channel state, register file, shift-add multiplier,
// restoring divider and result register. Depends on scse_pkg.
`default_nettype none
module scse_dp import scse_pkg::*; #(
    parameter int CPU_CLOCK_HZ   = 4194304,
    parameter int SAMPLE_RATE_HZ = 44100
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [IN_DATA_W-1:0]  i_in_data,
    input  wire logic [2:0]            i_in_kind,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    output logic [OUT_DATA_W-1:0]      o_out_data,
    output logic                       o_out_on
);
    localparam logic [63:0] MULT = 64'(CPU_CLOCK_HZ) << 13;
    localparam int MW = $clog2(MULT + 64'd1);
    localparam longint unsigned DMAX = longint'(SAMPLE_RATE_HZ) * 8192;
    localparam int DVW = $clog2(DMAX + 1);
    localparam logic [63:0] RATE_X4 = 64'(SAMPLE_RATE_HZ) * 64'd4;

    // latched request
    logic [2:0]  r_kind, r_reg;
    logic [7:0]  r_wd;
    logic [31:0] r_t;

    // channel state
    logic [7:0]  r_swp_byte, r_len_byte, r_env_byte, r_ctl_byte;
    logic [6:0]  r_len_left, r_len_rel;
    logic        r_len_en, r_env_up, r_swp_down, r_ovf, r_ref_valid;
    logic [1:0]  r_duty;
    logic [3:0]  r_vol;
    logic [2:0]  r_env_per, r_env_cd, r_swp_per, r_swp_shift, r_swp_cd;
    logic [10:0] r_freq, r_shadow;
    logic [15:0] r_phase, r_ref_phase;
    logic [31:0] r_ref_time;

    logic [7:0]  n_swp_byte, n_len_byte, n_env_byte, n_ctl_byte;
    logic [6:0]  n_len_left, n_len_rel;
    logic        n_len_en, n_env_up, n_swp_down, n_ovf, n_ref_valid;
    logic [1:0]  n_duty;
    logic [3:0]  n_vol;
    logic [2:0]  n_env_per, n_env_cd, n_swp_per, n_swp_shift, n_swp_cd;
    logic [10:0] n_freq, n_shadow;
    logic [15:0] n_phase, n_ref_phase;
    logic [31:0] n_ref_time;

    // arithmetic unit
    logic [63:0]    r_mcand, r_acc, r_dvd;
    logic [5:0]     r_cnt;
    logic [DVW-1:0] r_dvs, r_rem;
    logic [15:0]    r_quo;
    logic [DVW:0]   rem_sh;
    logic           qbit;
    logic [DVW-1:0] dvs_calc;

    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_on;

    logic        fire;
    logic [10:0] fnew;
    logic [11:0] ssum;
    logic [10:0] sd;
    logic        on;
    logic [15:0] smp, mag;
    logic [7:0]  rd;
    logic [7:0]  pat;

    assign o_stat.need_div = (r_kind == KIND_SAMPLE) && r_ref_valid;
    assign o_stat.mul_done = (r_cnt == 6'(MW - 1));
    assign o_stat.div_done = (r_cnt == 6'd63);
    assign o_out_data      = r_out_data;
    assign o_out_on        = r_out_on;

    always_comb begin
        n_swp_byte = r_swp_byte;   n_len_byte = r_len_byte;
        n_env_byte = r_env_byte;   n_ctl_byte = r_ctl_byte;
        n_len_left = r_len_left;   n_len_rel = r_len_rel;
        n_len_en = r_len_en;       n_env_up = r_env_up;
        n_swp_down = r_swp_down;   n_ovf = r_ovf;
        n_ref_valid = r_ref_valid; n_duty = r_duty;
        n_vol = r_vol;             n_env_per = r_env_per;
        n_env_cd = r_env_cd;       n_swp_per = r_swp_per;
        n_swp_shift = r_swp_shift; n_swp_cd = r_swp_cd;
        n_freq = r_freq;           n_shadow = r_shadow;
        n_phase = r_phase;         n_ref_phase = r_ref_phase;
        n_ref_time = r_ref_time;
        fire = 1'b0;
        fnew = '0;
        sd   = '0;
        ssum = '0;
        unique case (r_kind)
            KIND_WRITE: begin
                unique case (r_reg)
                    REG_SWEEP: begin
                        n_swp_byte  = r_wd;
                        n_swp_per   = r_wd[6:4];
                        n_swp_down  = r_wd[3];
                        n_swp_shift = r_wd[2:0];
                    end
                    REG_LEN: begin
                        n_len_byte = r_wd;
                        n_len_rel  = 7'd64 - {1'b0, r_wd[5:0]};
                        n_len_left = n_len_rel;
                        n_duty     = r_wd[7:6];
                    end
                    REG_ENV: begin
                        n_env_byte = r_wd;
                        n_vol      = r_wd[7:4];
                        n_env_up   = r_wd[3];
                        n_env_per  = r_wd[2:0];
                    end
                    REG_FLO: begin
                        fnew = {r_freq[10:8], r_wd};
                        if (fnew != r_freq) begin
                            n_freq      = fnew;
                            n_ref_valid = 1'b0;
                        end
                        n_len_left = r_len_rel;
                    end
                    REG_FHI: begin
                        fnew = {r_wd[2:0], r_freq[7:0]};
                        if (fnew != r_freq) begin
                            n_freq      = fnew;
                            n_ref_valid = 1'b0;
                        end
                        n_ctl_byte = r_wd;
                        n_len_en   = r_wd[6];
                        n_len_left = r_len_rel;
                        if (r_wd[7]) begin
                            // trigger
                            n_env_cd = r_env_per;
                            n_vol    = r_env_byte[7:4];
                            if (n_len_left == 7'd0) n_len_left = 7'd64;
                            n_phase     = '0;
                            n_ref_valid = 1'b0;
                            n_shadow    = n_freq;
                            n_ovf       = 1'b0;
                            fire = (r_swp_per != 3'd0) && (r_swp_shift != 3'd0);
                        end
                    end
                    default: ;
                endcase
            end
            KIND_LENGTH: begin
                if (r_len_left != 7'd0) n_len_left = r_len_left - 7'd1;
            end
            KIND_ENV: begin
                if (r_env_per != 3'd0 && r_env_cd != 3'd0) begin
                    n_env_cd = r_env_cd - 3'd1;
                    if (n_env_cd == 3'd0) begin
                        n_env_cd = r_env_per;
                        if (r_env_up) begin
                            if (r_vol != 4'd15) n_vol = r_vol + 4'd1;
                        end else if (r_vol != 4'd0) begin
                            n_vol = r_vol - 4'd1;
                        end
                    end
                end
            end
            KIND_SWEEP: begin
                if (r_swp_per != 3'd0 && r_swp_shift != 3'd0 && r_swp_cd != 3'd0) begin
                    n_swp_cd = r_swp_cd - 3'd1;
                    fire     = (n_swp_cd == 3'd0);
                end
            end
            KIND_SAMPLE: begin
                if (!r_ref_valid) begin
                    n_ref_valid = 1'b1;
                    n_ref_time  = r_t;
                    n_ref_phase = r_phase;
                end
            end
            default: ;
        endcase
        if (fire) begin
            n_swp_cd = r_swp_per;
            if (n_shadow != n_freq) begin
                n_freq      = n_shadow;
                n_ref_valid = 1'b0;
            end
            sd   = n_shadow >> r_swp_shift;
            ssum = r_swp_down ? ({1'b0, n_shadow} - {1'b0, sd})
                              : ({1'b0, n_shadow} + {1'b0, sd});
            if (ssum[11]) begin
                n_swp_cd = 3'd0;
                n_ovf    = 1'b1;
                n_shadow = '0;
            end else begin
                n_shadow = ssum[10:0];
            end
        end
    end

    assign on = (!r_len_en || r_len_left != 7'd0) && r_vol != 4'd0 &&
                r_freq != 11'd0 && r_freq <= 11'd2041 && !r_ovf;
    assign mag = vol_mag(r_vol);
    assign pat = duty_pattern(r_duty);

    always_comb begin
        smp = '0;
        rd  = '0;
        if (r_kind == KIND_SAMPLE && on) begin
            smp = pat[r_phase[15:13]] ? mag : 16'(-mag);
        end
        if (r_kind == KIND_READ) begin
            unique case (r_reg)
                REG_SWEEP: rd = r_swp_byte | 8'h80;
                REG_LEN:   rd = r_len_byte | 8'h3F;
                REG_ENV:   rd = r_env_byte;
                REG_FHI:   rd = r_ctl_byte | 8'hBF;
                default:   rd = 8'hFF;
            endcase
        end
    end

    assign dvs_calc = DVW'(RATE_X4 * (64'd2048 - 64'(r_freq)));
    assign rem_sh   = {r_rem, r_dvd[63]};
    assign qbit     = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swp_byte <= '0; r_len_byte <= '0; r_env_byte <= '0; r_ctl_byte <= '0;
            r_len_left <= '0; r_len_rel <= '0; r_len_en <= 1'b0; r_env_up <= 1'b0;
            r_swp_down <= 1'b0; r_ovf <= 1'b0; r_ref_valid <= 1'b0; r_duty <= '0;
            r_vol <= '0; r_env_per <= '0; r_env_cd <= '0; r_swp_per <= '0;
            r_swp_shift <= '0; r_swp_cd <= '0; r_freq <= '0; r_shadow <= '0;
            r_phase <= '0; r_ref_phase <= '0; r_ref_time <= '0;
        end else if (i_cmd.apply) begin
            r_swp_byte <= n_swp_byte; r_len_byte <= n_len_byte;
            r_env_byte <= n_env_byte; r_ctl_byte <= n_ctl_byte;
            r_len_left <= n_len_left; r_len_rel <= n_len_rel;
            r_len_en <= n_len_en; r_env_up <= n_env_up;
            r_swp_down <= n_swp_down; r_ovf <= n_ovf;
            r_ref_valid <= n_ref_valid; r_duty <= n_duty;
            r_vol <= n_vol; r_env_per <= n_env_per;
            r_env_cd <= n_env_cd; r_swp_per <= n_swp_per;
            r_swp_shift <= n_swp_shift; r_swp_cd <= n_swp_cd;
            r_freq <= n_freq; r_shadow <= n_shadow;
            r_phase <= n_phase; r_ref_phase <= n_ref_phase;
            r_ref_time <= n_ref_time;
        end else if (i_cmd.finish) begin
            r_phase <= r_ref_phase + r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_reg  <= i_in_data[2:0];
            r_wd   <= i_in_data[10:3];
            r_t    <= i_in_data[42:11];
            r_kind <= i_in_kind;
        end
        if (i_cmd.mul_init) begin
            r_mcand <= {32'd0, r_t} - {32'd0, r_ref_time};
            r_acc   <= '0;
            r_cnt   <= '0;
            r_dvs   <= dvs_calc;
        end else if (i_cmd.mul_step) begin
            // product wraps at 64 bits
            if (MULT[r_cnt]) r_acc <= r_acc + r_mcand;
            r_mcand <= r_mcand << 1;
            r_cnt   <= r_cnt + 6'd1;
        end else if (i_cmd.div_init) begin
            r_dvd <= r_acc;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= qbit ? DVW'(rem_sh - {1'b0, r_dvs}) : rem_sh[DVW-1:0];
            r_quo <= {r_quo[14:0], qbit};
            r_dvd <= r_dvd << 1;
            r_cnt <= r_cnt + 6'd1;
        end
        if (i_cmd.emit) begin
            r_out_data <= {rd, smp};
            r_out_on   <= on;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/square_channel_sweep_envelope_top.sv =====
// Square tone channel with sweep, envelope, length counter and duty patterns.
// Non-sample requests and first samples pass through the load, apply and emit states;
// a phase-advancing sample also runs the MW-step bit-serial multiplier (MW = bit length
// of CPU_CLOCK_HZ << 13, 36 at defaults) and the 64-step restoring divider before emit.
// One request in flight; the next is taken once the result is registered.
// Reset: synchronous active-low i_rst_n clears all channel state and the output valid.
`default_nettype none
module square_channel_sweep_envelope_top import scse_pkg::*; #(
    parameter int CPU_CLOCK_HZ   = 4194304,
    parameter int SAMPLE_RATE_HZ = 44100
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // reg_index, write_data, sample_time
    input  wire logic [2:0]            s_axis_tuser,  // kind
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // sample, read_data
    output logic                       m_axis_tuser   // channel_on
);
    t_cmd  cmd;
    t_stat stat;

    scse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    scse_dp #(
        .CPU_CLOCK_HZ   (CPU_CLOCK_HZ),
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (s_axis_tdata),
        .i_in_kind  (s_axis_tuser),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (m_axis_tdata),
        .o_out_on   (m_axis_tuser)
    );
endmodule
`default_nettype wire

// ===== rtl/core/scse_checker.sv =====
// Port-level checks for the square tone channel, bound to the top level.
// Depends on scse_pkg for port widths.
`default_nettype none
module scse_checker import scse_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                  m_axis_tuser
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    a_off_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:0] == 16'd0)
        else $error("nonzero sample with channel off");

    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:0] == 16'd0 || m_axis_tdata[23:16] == 8'd0)
        else $error("sample and read data both set");
endmodule

bind square_channel_sweep_envelope_top scse_checker u_scse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking bench for the square tone channel: directed table, then random requests.
// Depends on scse_pkg and square_channel_sweep_envelope_top.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import scse_pkg::*;

    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;
    localparam logic [2:0] REG_NONE5   = 3'd5;
    localparam logic [2:0] REG_NONE7   = 3'd7;
    localparam int CPU_HZ      = 4194304;
    localparam int RATE_HZ     = 44100;
    localparam int IDLE_LIMIT  = 4000;
    localparam int N_RANDOM    = 700;

    typedef struct packed {
        logic [15:0] smp;
        logic [7:0]  rd;
        logic        on;
    } chan_result_t;

    typedef struct {
        logic [2:0]   kind;
        logic [2:0]   idx;
        logic [7:0]   data;
        logic [31:0]  t;
        bit           typed;
        chan_result_t res;
    } stim_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // reg_index, write_data, sample_time
    logic [2:0]            s_axis_tuser = '0;  // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;       // sample, read_data
    logic                  m_axis_tuser;       // channel_on

    square_channel_sweep_envelope_top #(.CPU_CLOCK_HZ(CPU_HZ), .SAMPLE_RATE_HZ(RATE_HZ)) dut (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // channel model state
    logic [7:0]  r_sweep, r_len, r_env, r_ctrl;
    logic [6:0]  len_left, len_reload;
    logic        len_en, env_up, sw_down, sw_ovf, ref_ok;
    logic [1:0]  duty;
    logic [3:0]  vol;
    logic [2:0]  env_per, env_cnt, sw_per, sw_shift, sw_cnt;
    logic [10:0] freq, shadow;
    logic [15:0] phase, ref_phase;
    logic [31:0] ref_t;

    chan_result_t expected_q[$];
    int  errors = 0;
    int  idle_cycles = 0;

    task automatic model_reset();
        {r_sweep, r_len, r_env, r_ctrl} = '0;
        {len_left, len_reload, len_en, env_up, sw_down, sw_ovf, ref_ok} = '0;
        {duty, vol, env_per, env_cnt, sw_per, sw_shift, sw_cnt} = '0;
        {freq, shadow, phase, ref_phase, ref_t} = '0;
    endtask

    task automatic set_tone(input logic [10:0] f);
        if (f != freq) begin
            freq = f;
            ref_ok = 1'b0;
        end
    endtask

    task automatic sweep_step(input bit forced);
        logic [11:0] s, d;
        if (!forced) begin
            if (sw_per == 0 || sw_shift == 0 || sw_cnt == 0) return;
            sw_cnt = sw_cnt - 3'd1;
            if (sw_cnt != 0) return;
        end
        sw_cnt = sw_per;
        set_tone(shadow);
        s = {1'b0, shadow};
        d = s >> sw_shift;
        s = sw_down ? s - d : s + d;   // going down never wraps since d <= s
        if (s >= 12'd2048) begin
            sw_cnt = '0;
            sw_ovf = 1'b1;
            shadow = '0;
        end else begin
            shadow = s[10:0];
        end
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [7:0] v);
        case (idx)
            REG_SWEEP: begin
                r_sweep = v; sw_per = v[6:4]; sw_down = v[3]; sw_shift = v[2:0];
            end
            REG_LEN: begin
                r_len = v; len_reload = 7'd64 - {1'b0, v[5:0]}; len_left = len_reload;
                duty = v[7:6];
            end
            REG_ENV: begin
                r_env = v; vol = v[7:4]; env_up = v[3]; env_per = v[2:0];
            end
            REG_FLO: begin
                set_tone({freq[10:8], v});
                len_left = len_reload;
            end
            REG_FHI: begin
                set_tone({v[2:0], freq[7:0]});
                r_ctrl = v; len_en = v[6]; len_left = len_reload;
                if (v[7]) begin
                    env_cnt = env_per;
                    vol = r_env[7:4];
                    if (len_left == 0) len_left = 7'd64;
                    phase = '0;
                    ref_ok = 1'b0;
                    shadow = freq;
                    sw_ovf = 1'b0;
                    if (sw_per != 0 && sw_shift != 0) sweep_step(1'b1);
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic [7:0] reg_read(input logic [2:0] idx);
        case (idx)
            REG_SWEEP: return r_sweep | 8'h80;
            REG_LEN:   return r_len | 8'h3F;
            REG_ENV:   return r_env;
            REG_FHI:   return r_ctrl | 8'hBF;
            default:   return 8'hFF;
        endcase
    endfunction

    function automatic logic channel_enabled();
        return (!len_en || len_left != 0) && vol != 0 && freq != 0 && freq <= 11'd2041
               && !sw_ovf;
    endfunction

    task automatic tone_sample(input logic [31:0] t, output logic [15:0] smp);
        logic [63:0] delta, scale, denom, q;
        int          mag;
        logic [7:0]  pat;
        if (!ref_ok) begin
            ref_ok = 1'b1; ref_t = t; ref_phase = phase;
        end else begin
            delta = {32'd0, t} - {32'd0, ref_t};
            scale = 64'(CPU_HZ) << 13;
            denom = 64'(RATE_HZ) * (64'(12'd2048 - {1'b0, freq}) * 64'd4);
            q = (denom != 0) ? (delta * scale) / denom : 64'd0;
            phase = ref_phase + q[15:0];
        end
        smp = '0;
        if (channel_enabled()) begin
            mag = int'(vol) * 32767 / 15;
            pat = duty_pattern(duty);
            smp = pat[phase[15:13]] ? 16'(mag) : 16'(-mag);
        end
    endtask

    task automatic predict_channel(input logic [2:0] kind, input logic [2:0] idx,
                                   input logic [7:0] data, input logic [31:0] t,
                                   output chan_result_t r);
        r = '0;
        case (kind)
            KIND_WRITE:  reg_write(idx, data);
            KIND_READ:   r.rd = reg_read(idx);
            KIND_LENGTH: if (len_left != 0) len_left = len_left - 7'd1;
            KIND_ENV: begin
                if (env_per != 0 && env_cnt != 0) begin
                    env_cnt = env_cnt - 3'd1;
                    if (env_cnt == 0) begin
                        env_cnt = env_per;
                        if (env_up && vol < 4'd15) vol = vol + 4'd1;
                        else if (!env_up && vol > 4'd0) vol = vol - 4'd1;
                    end
                end
            end
            KIND_SWEEP:  sweep_step(1'b0);
            KIND_SAMPLE: tone_sample(t, r.smp);
            default: ;
        endcase
        r.on = channel_enabled();
    endtask

    // request driver: one request at a time, valid changes only at falling edges
    int burst_left = 0;
    task automatic send_request(input logic [2:0] kind, input logic [2:0] idx,
                                input logic [7:0] data, input logic [31:0] t,
                                input bit typed, input chan_result_t typed_res);
        chan_result_t r;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'd0, t, data, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_channel(kind, idx, data, t, r);
        expected_q.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    // receiver stall pattern: a randomly chosen mode drives ready (always, random or periodic)
    int rx_cyc = 0;
    int rx_mode = 0;
    always @(negedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        if (rx_cyc % 64 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0, 3: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            default: m_axis_tready <= (rx_cyc % 5 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        chan_result_t want, got;
        if (m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[15:0], m_axis_tdata[23:16], m_axis_tuser};
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result smp=%0d rd=%02h on=%0b", $time,
                         $signed(got.smp), got.rd, got.on);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.smp != want.smp) begin
                    $display("%0t: sample expected %0d actual %0d", $time,
                             $signed(want.smp), $signed(got.smp));
                    errors++;
                end
                if (got.rd != want.rd) begin
                    $display("%0t: read_data expected %02h actual %02h", $time,
                             want.rd, got.rd);
                    errors++;
                end
                if (got.on != want.on) begin
                    $display("%0t: channel_on expected %0b actual %0b", $time,
                             want.on, got.on);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles where neither side moves a request
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    stim_row_t directed[] = '{
        '{KIND_READ,   REG_SWEEP, 8'h00, 32'd0, 1, '{16'd0, 8'h80, 1'b0}},
        '{KIND_READ,   REG_LEN,   8'h00, 32'd0, 1, '{16'd0, 8'h3F, 1'b0}},
        '{KIND_READ,   REG_FLO,   8'h00, 32'd0, 1, '{16'd0, 8'hFF, 1'b0}},
        '{KIND_READ,   REG_NONE7, 8'h00, 32'd0, 1, '{16'd0, 8'hFF, 1'b0}},
        '{KIND_SPARE6, REG_FHI,   8'hFF, 32'hFFFFFFFF, 1, '{16'd0, 8'h00, 1'b0}},
        '{KIND_SPARE7, REG_NONE7, 8'hFF, 32'hFFFFFFFF, 1, '{16'd0, 8'h00, 1'b0}},
        '{KIND_WRITE,  REG_NONE5, 8'hFF, 32'd0, 1, '{16'd0, 8'h00, 1'b0}},
        '{KIND_SAMPLE, REG_SWEEP, 8'h00, 32'd0, 1, '{16'd0, 8'h00, 1'b0}},
        // sweep up by half from the top frequency overflows on trigger
        '{KIND_WRITE,  REG_SWEEP, 8'h11, 32'd0, 0, '0},
        '{KIND_WRITE,  REG_LEN,   8'hC0, 32'd0, 0, '0},
        '{KIND_WRITE,  REG_ENV,   8'hF9, 32'd0, 0, '0},
        '{KIND_WRITE,  REG_FLO,   8'hFF, 32'd0, 0, '0},
        '{KIND_WRITE,  REG_FHI,   8'h87, 32'd0, 0, '0},
        '{KIND_READ,   REG_FHI,   8'h00, 32'd0, 1, '{16'd0, 8'hBF, 1'b0}},
        '{KIND_WRITE,  REG_SWEEP, 8'h7F, 32'd0, 0, '0},
        '{KIND_WRITE,  REG_FHI,   8'hC3, 32'd0, 0, '0},
        '{KIND_SAMPLE, REG_SWEEP, 8'h00, 32'hFFFFFFFF, 0, '0},
        '{KIND_SAMPLE, REG_SWEEP, 8'h00, 32'd300, 0, '0},
        '{KIND_SAMPLE, REG_SWEEP, 8'h00, 32'd0, 0, '0},
        '{KIND_ENV,    REG_SWEEP, 8'h00, 32'd0, 0, '0},
        '{KIND_SWEEP,  REG_SWEEP, 8'h00, 32'd0, 0, '0},
        '{KIND_LENGTH, REG_SWEEP, 8'h00, 32'd0, 0, '0},
        '{KIND_WRITE,  REG_ENV,   8'h09, 32'd0, 0, '0},
        '{KIND_ENV,    REG_SWEEP, 8'h00, 32'd0, 0, '0},
        '{KIND_SAMPLE, REG_SWEEP, 8'h00, 32'd1000, 0, '0}
    };

    initial begin
        logic [2:0]  kind, idx;
        logic [7:0]  data;
        logic [31:0] t;
        int          sel;
        model_reset();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed[i])
            send_request(directed[i].kind, directed[i].idx, directed[i].data,
                         directed[i].t, directed[i].typed, directed[i].res);
        t = $urandom;
        for (int n = 0; n < N_RANDOM; n++) begin
            sel  = $urandom_range(0, 99);
            idx  = 3'($urandom_range(0, 4));
            data = 8'($urandom);
            if (sel < 22) begin
                kind = KIND_WRITE;
                if ($urandom_range(0, 9) == 0) idx = 3'($urandom_range(5, 7));
                // keep volume up most of the time so samples are audible
                if (idx == REG_ENV && $urandom_range(0, 3) != 0)
                    data[7:4] = 4'($urandom_range(4, 15));
            end else if (sel < 32) begin
                kind = KIND_READ;
                idx  = 3'($urandom_range(0, 7));
            end else if (sel < 60) begin
                kind = 3'($urandom_range(2, 4));
            end else if (sel < 97) begin
                kind = KIND_SAMPLE;
            end else begin
                kind = 3'($urandom_range(6, 7));
                idx  = 3'($urandom_range(0, 7));
            end
            case ($urandom_range(0, 9))
                0:       t = $urandom;
                1:       t = t - $urandom_range(0, 500);
                2, 3:    t = t + $urandom_range(0, 20000);
                default: t = t + $urandom_range(0, 400);
            endcase
            send_request(kind, idx, data, t, 0, '0);
        end
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/scse_pkg.sv
rtl/core/scse_ctrl.sv
rtl/core/scse_dp.sv
rtl/core/square_channel_sweep_envelope_top.sv
rtl/core/scse_checker.sv
test/tb.sv
